// File: design/disparity_to_point_reprojection_defines.svh
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_defines
// Assertion macros shared by the reprojection design.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_REPROJECTION_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECTION_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define D2P_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define D2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/d2p_pkg.sv
// ----------------------------------------------------------------------------
// d2p_pkg
// Types and constants of the disparity to 3D point reprojection block.
// ----------------------------------------------------------------------------
package d2p_pkg;

  localparam int unsigned PixW  = 12;
  localparam int unsigned RegW  = 16;
  localparam int unsigned AddrW = 3;

  // Register indexes
  localparam logic [AddrW-1:0] RegFocal  = 3'd0;
  localparam logic [AddrW-1:0] RegCenCol = 3'd1;
  localparam logic [AddrW-1:0] RegCenRow = 3'd2;
  localparam logic [AddrW-1:0] RegBase   = 3'd3;
  localparam logic [AddrW-1:0] RegMinDisp = 3'd4;

  // Reset values
  localparam logic [RegW-1:0] FocalRst   = 16'd11552;
  localparam logic [RegW-1:0] CenColRst  = 16'd9856;
  localparam logic [RegW-1:0] CenRowRst  = 16'd2944;
  localparam logic [RegW-1:0] BaseRst    = 16'd2212;
  localparam logic [RegW-1:0] MinDispRst = 16'd10240;

  localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  typedef struct packed {
    logic [PixW-1:0] pixel_col;
    logic [PixW-1:0] pixel_row;
    logic [15:0]     disparity;
    logic [7:0]      gray_level;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        point_z;
    logic [7:0]         point_gray;
    logic [PixW-1:0]    source_row;
    logic [PixW-1:0]    source_col;
  } point_t;

endpackage

// File: design/disparity_to_point_reprojection.sv
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Turns disparity pixels into saturated Q16.16 3D points through a
// multiply stage and a pipelined restoring divider, one lane per axis.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  pixel   | in_valid_i, in_ready_o, in_data_i | in
//  point   | out_valid_o, out_ready_i, out_data_o | out
//  config  | cfg_we_i, cfg_addr_i, cfg_wdata_i | in
//
//  One pixel enters per cycle while the output is not stalled.
//  The pipeline holds the 32 quotient steps, four per stage over eight
//  divider stages, plus input, multiply, divider set-up and output stages.
//  Reset clears all valid bits and restores the register defaults.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
//  Pixels whose disparity is not above the minimum are dropped at entry.
`include "disparity_to_point_reprojection_defines.svh"

module disparity_to_point_reprojection #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  d2p_pkg::pixel_t             in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output d2p_pkg::point_t             out_data_o,
  input  logic                        cfg_we_i,
  input  logic [d2p_pkg::AddrW-1:0]   cfg_addr_i,
  input  logic [d2p_pkg::RegW-1:0]    cfg_wdata_i
);
  import d2p_pkg::*;

  localparam int unsigned DivStages = 8;
  localparam int unsigned StepsPerStage = 4;
  localparam logic [PixW-1:0] CoordMask =
    (COORD_BITS >= PixW) ? {PixW{1'b1}} : PixW'((1 << COORD_BITS) - 1);

  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] bits;
  } div_t;

  typedef struct packed {
    logic [7:0]      gray;
    logic [PixW-1:0] row;
    logic [PixW-1:0] col;
    logic [15:0]     disp;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            ovf_z;
  } meta_t;

  // One restoring division step
  function automatic div_t div_step(div_t s, logic [15:0] dv);
    logic [16:0] t;
    logic [16:0] diff;
    div_t r;
    t = {s.rem, s.bits[31]};
    diff = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      r.rem  = diff[15:0];
      r.bits = {s.bits[30:0], 1'b1};
    end else begin
      r.rem  = t[15:0];
      r.bits = {s.bits[30:0], 1'b0};
    end
    return r;
  endfunction

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Configuration registers
  logic [RegW-1:0] focal_q, cen_col_q, cen_row_q, base_q, min_disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q    <= FocalRst;
      cen_col_q  <= CenColRst;
      cen_row_q  <= CenRowRst;
      base_q     <= BaseRst;
      min_disp_q <= MinDispRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegFocal:   focal_q    <= cfg_wdata_i;
        RegCenCol:  cen_col_q  <= cfg_wdata_i;
        RegCenRow:  cen_row_q  <= cfg_wdata_i;
        RegBase:    base_q     <= cfg_wdata_i;
        RegMinDisp: min_disp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage A: mask coordinates, centre them, qualify the disparity
  logic              a_vld_q;
  logic [PixW-1:0]   a_col_q, a_row_q;
  logic [15:0]       a_disp_q;
  logic [7:0]        a_gray_q;
  logic signed [17:0] a_ncol_q, a_nrow_q;
  logic [PixW-1:0]   a_col_d, a_row_d;
  logic              a_vld_d;

  assign a_col_d = in_data_i.pixel_col & CoordMask;
  assign a_row_d = in_data_i.pixel_row & CoordMask;
  assign a_vld_d = in_valid_i && (in_data_i.disparity > min_disp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= a_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_col_q  <= a_col_d;
      a_row_q  <= a_row_d;
      a_disp_q <= in_data_i.disparity;
      a_gray_q <= in_data_i.gray_level;
      a_ncol_q <= $signed({2'b00, a_col_d, 4'b0000}) - $signed({2'b00, cen_col_q});
      a_nrow_q <= $signed({2'b00, a_row_d, 4'b0000}) - $signed({2'b00, cen_row_q});
    end
  end

  // Stage B: magnitudes and focal length times baseline
  logic        b_vld_q;
  logic [31:0] b_px_q, b_py_q, b_pz_q;
  meta_t       b_meta_q;
  logic [15:0] mag_x, mag_y;

  assign mag_x = a_ncol_q[17] ? 16'(-a_ncol_q) : 16'(a_ncol_q);
  assign mag_y = a_nrow_q[17] ? 16'(-a_nrow_q) : 16'(a_nrow_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_px_q <= 32'(mag_x) * 32'(base_q);
      b_py_q <= 32'(mag_y) * 32'(base_q);
      b_pz_q <= 32'(focal_q) * 32'(base_q);
      b_meta_q.gray  <= a_gray_q;
      b_meta_q.row   <= a_row_q;
      b_meta_q.col   <= a_col_q;
      b_meta_q.disp  <= a_disp_q;
      b_meta_q.neg_x <= a_ncol_q[17];
      b_meta_q.neg_y <= a_nrow_q[17];
      b_meta_q.ovf_x <= 1'b0;
      b_meta_q.ovf_y <= 1'b0;
      b_meta_q.ovf_z <= 1'b0;
    end
  end

  // Divider stages: index 0 is set-up, the rest take four quotient bits each
  logic  dv_vld_q [DivStages+1];
  meta_t dv_meta_q [DivStages+1];
  div_t  dx_q [DivStages+1];
  div_t  dy_q [DivStages+1];
  div_t  dz_q [DivStages+1];
  meta_t dv_meta_d [DivStages+1];
  div_t  dx_d [DivStages+1];
  div_t  dy_d [DivStages+1];
  div_t  dz_d [DivStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DivStages; i++) dv_vld_q[i] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= b_vld_q;
      for (int i = 1; i <= DivStages; i++) dv_vld_q[i] <= dv_vld_q[i-1];
    end
  end

  // Flag a quotient of 2^32 or more, seed the remainder with the top byte,
  // then advance four quotient bits per stage
  always_comb begin
    div_t tx, ty, tz;
    dv_meta_d[0]       = b_meta_q;
    dv_meta_d[0].ovf_x = {8'h00, b_px_q[31:24]} >= b_meta_q.disp;
    dv_meta_d[0].ovf_y = {8'h00, b_py_q[31:24]} >= b_meta_q.disp;
    dv_meta_d[0].ovf_z = {8'h00, b_pz_q[31:24]} >= b_meta_q.disp;
    dx_d[0] = '{rem: {8'h00, b_px_q[31:24]}, bits: {b_px_q[23:0], 8'h00}};
    dy_d[0] = '{rem: {8'h00, b_py_q[31:24]}, bits: {b_py_q[23:0], 8'h00}};
    dz_d[0] = '{rem: {8'h00, b_pz_q[31:24]}, bits: {b_pz_q[23:0], 8'h00}};
    for (int k = 1; k <= DivStages; k++) begin
      dv_meta_d[k] = dv_meta_q[k-1];
      tx = dx_q[k-1];
      ty = dy_q[k-1];
      tz = dz_q[k-1];
      for (int s = 0; s < StepsPerStage; s++) begin
        tx = div_step(tx, dv_meta_q[k-1].disp);
        ty = div_step(ty, dv_meta_q[k-1].disp);
        tz = div_step(tz, dv_meta_q[k-1].disp);
      end
      dx_d[k] = tx;
      dy_d[k] = ty;
      dz_d[k] = tz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= DivStages; i++) begin
        dv_meta_q[i] <= dv_meta_d[i];
        dx_q[i]      <= dx_d[i];
        dy_q[i]      <= dy_d[i];
        dz_q[i]      <= dz_d[i];
      end
    end
  end

  // Output stage: apply signs and saturate
  meta_t       fm;
  logic [31:0] qx, qy, qz;
  logic [31:0] px_d, py_d;
  logic [30:0] pz_d;

  assign fm = dv_meta_q[DivStages];
  assign qx = dx_q[DivStages].bits;
  assign qy = dy_q[DivStages].bits;
  assign qz = dz_q[DivStages].bits;

  always_comb begin
    if (fm.neg_x) px_d = (fm.ovf_x || qx[31]) ? SatPos : qx;
    else          px_d = (fm.ovf_x || qx > SatNeg) ? SatNeg : 32'(-qx);
    if (fm.neg_y) py_d = (fm.ovf_y || qy[31]) ? SatPos : qy;
    else          py_d = (fm.ovf_y || qy > SatNeg) ? SatNeg : 32'(-qy);
    pz_d = (fm.ovf_z || qz[31]) ? SatPos[30:0] : qz[30:0];
  end

  logic   out_vld_q;
  point_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.point_x    <= px_d;
      out_q.point_y    <= py_d;
      out_q.point_z    <= pz_d;
      out_q.point_gray <= fm.gray;
      out_q.source_row <= fm.row;
      out_q.source_col <= fm.col;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Assertions
  `D2P_ASSERT_NEXT(a_drop_small, in_valid_i && en && (in_data_i.disparity <= min_disp_q), !a_vld_q)
  `D2P_ASSERT_NEXT(a_stall_hold, !en, $stable(dv_vld_q[DivStages]) && $stable(a_vld_q))
  `D2P_ASSERT_SAME(a_ready_free, !out_valid_o, in_ready_o)

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pixel transfers into the reprojection block under several register
// settings and idling patterns, predicts each 3D point from the register
// values and checks every point transfer against the oldest prediction, in order.
// ----------------------------------------------------------------------------
module testbench;
  import d2p_pkg::*;

  localparam logic [AddrW-1:0] FirstUnusedReg = 3'd5;
  localparam int unsigned      DrainCycles    = 30;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  pixel_t          in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  point_t          out_data_o;
  logic            cfg_we_i;
  logic [AddrW-1:0] cfg_addr_i;
  logic [RegW-1:0] cfg_wdata_i;

  disparity_to_point_reprojection dut (.*);

  // Register copies used for prediction
  logic [RegW-1:0] focal_reg, ccol_reg, crow_reg, base_reg, mind_reg;

  pixel_t pixel_queue[$];
  point_t point_queue[$];
  int     send_idle, recv_stall;
  bit     hold_tx;
  int     mismatches;
  int     failures;
  logic   busy;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // -(n)*B*256/d, saturated Q16.16
  function automatic logic [31:0] lateral_q16(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag * base_reg * 256) / d;
    if (n < 0) begin
      if (q > SatPos) q = SatPos;
      return q[31:0];
    end
    if (q > SatNeg) q = SatNeg;
    return 32'(64'd0 - q);
  endfunction

  function automatic point_t project_pixel(pixel_t p);
    point_t          pt;
    longint          ncol, nrow;
    longint unsigned z;
    ncol = longint'({p.pixel_col, 4'd0}) - longint'(ccol_reg);
    nrow = longint'({p.pixel_row, 4'd0}) - longint'(crow_reg);
    z = (longint'(focal_reg) * base_reg * 256) / p.disparity;
    if (z > SatPos) z = SatPos;
    pt.point_x    = lateral_q16(ncol, p.disparity);
    pt.point_y    = lateral_q16(nrow, p.disparity);
    pt.point_z    = z[30:0];
    pt.point_gray = p.gray_level;
    pt.source_row = p.pixel_row;
    pt.source_col = p.pixel_col;
    return pt;
  endfunction

  // Mostly pixels above the minimum disparity, some dropped ones
  function automatic pixel_t random_pixel();
    pixel_t p;
    p.pixel_col  = 12'($urandom);
    p.pixel_row  = 12'($urandom);
    p.gray_level = 8'($urandom);
    if ($urandom_range(99) < 80 && mind_reg != 16'hFFFF)
      p.disparity = 16'($urandom_range(65535, int'(mind_reg) + 1));
    else
      p.disparity = 16'($urandom);
    return p;
  endfunction

  // Driver: present queued pixels, predict on each accepted transfer above the minimum disparity
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o && in_data_i.disparity > mind_reg)
        point_queue = {point_queue, project_pixel(in_data_i)};
      busy = in_valid_i && !in_ready_o;
      if (!busy) begin
        if (pixel_queue.size() > 0 && !hold_tx && $urandom_range(99) >= send_idle) begin
          in_data_i  <= pixel_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check point transfers against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (point_queue.size() == 0) begin
          failures++;
          if (mismatches++ < 10) $display("unexpected point %p", out_data_o);
        end else if (out_data_o !== point_queue[0]) begin
          failures++;
          if (mismatches++ < 10)
            $display("point mismatch: expected %p actual %p", point_queue[0], out_data_o);
          void'(point_queue.pop_front());
        end else begin
          void'(point_queue.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [AddrW-1:0] idx, logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    unique case (idx)
      RegFocal:   focal_reg = val;
      RegCenCol:  ccol_reg  = val;
      RegCenRow:  crow_reg  = val;
      RegBase:    base_reg  = val;
      RegMinDisp: mind_reg  = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [RegW-1:0] f, logic [RegW-1:0] cc, logic [RegW-1:0] cr,
                           logic [RegW-1:0] b, logic [RegW-1:0] md);
    write_reg(RegFocal, f);
    write_reg(RegCenCol, cc);
    write_reg(RegCenRow, cr);
    write_reg(RegBase, b);
    write_reg(RegMinDisp, md);
    // unknown index, must be ignored
    write_reg(3'($urandom_range(7, int'(FirstUnusedReg))), 16'($urandom));
  endtask

  // Wait until all transfers are done and dropped pixels have left the pipe
  task automatic wait_quiet();
    while (pixel_queue.size() > 0 || in_valid_i || point_queue.size() > 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic queue_pixel(logic [11:0] c, logic [11:0] r, logic [15:0] d, logic [7:0] g);
    pixel_t p;
    p.pixel_col = c; p.pixel_row = r; p.disparity = d; p.gray_level = g;
    pixel_queue = {pixel_queue, p};
  endtask

  // Stimulus
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    hold_tx     = 1'b0;
    send_idle   = 0;
    recv_stall  = 0;
    mismatches  = 0;
    failures    = 0;
    focal_reg = FocalRst; ccol_reg = CenColRst; crow_reg = CenRowRst;
    base_reg  = BaseRst;  mind_reg = MinDispRst;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset values, field extremes, disparity around the minimum
    queue_pixel(12'd0, 12'd0, 16'd0, 8'd0);
    queue_pixel(12'd4095, 12'd4095, MinDispRst, 8'd255);
    queue_pixel(12'd0, 12'd4095, MinDispRst + 16'd1, 8'd255);
    queue_pixel(12'd4095, 12'd0, 16'hFFFF, 8'd0);
    queue_pixel(12'd616, 12'd184, 16'd20000, 8'd128);
    queue_pixel(12'hAAA, 12'h555, 16'hAAAA, 8'hAA);
    queue_pixel(12'h555, 12'hAAA, 16'h5555, 8'h55);
    wait_quiet();

    // Saturation: tiny disparity with a zero minimum, large constants
    write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_pixel(12'd4095, 12'd0, 16'd1, 8'd1);
    queue_pixel(12'd0, 12'd4095, 16'd1, 8'd2);
    queue_pixel(12'd0, 12'd0, 16'd0, 8'd3);
    queue_pixel(12'd4095, 12'd4095, 16'd2, 8'd4);
    queue_pixel(12'd2048, 12'd2048, 16'hFFFF, 8'd5);
    queue_pixel(12'd4095, 12'd0, 16'd255, 8'd6);
    wait_quiet();

    // All registers zero, then highest minimum (every pixel dropped)
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_pixel(12'd4095, 12'd4095, 16'd1, 8'd7);
    queue_pixel(12'd1, 12'd1, 16'hFFFF, 8'd8);
    wait_quiet();
    write_all(16'd11552, 16'd9856, 16'd2944, 16'd2212, 16'hFFFF);
    repeat (20) pixel_queue = {pixel_queue, random_pixel()};
    wait_quiet();

    // Random phases over idling patterns and register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      if (ph == 0)
        write_all(FocalRst, CenColRst, CenRowRst, BaseRst, MinDispRst);
      else if (ph == 4)
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      else
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(20000)));
      repeat (110) pixel_queue = {pixel_queue, random_pixel()};
      if (ph == 5) begin
        // Pause the sender until the pipe has drained
        repeat (200) @(negedge clk_i);
        hold_tx = 1'b1;
        while (point_queue.size() > 0) @(negedge clk_i);
        hold_tx = 1'b0;
      end
      wait_quiet();
    end

    failures += point_queue.size();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
